>>> hdl/two_range_frequency_meter_assert.svh
// ============================================================================
// Two-range frequency meter assertion macros
// Concurrent assertion wrappers; they expand to nothing in synthesis.
// ============================================================================
`ifndef TWO_RANGE_FREQUENCY_METER_ASSERT_SVH
`define TWO_RANGE_FREQUENCY_METER_ASSERT_SVH
`ifndef SYNTHESIS
// Same-cycle implication.
`define TRFM_ASSERT_IMPL(label, clk, rst, pre, post) \
   label: assert property (@(posedge clk) disable iff (rst) (pre) |-> (post)) \
      else $error("trfm: same-cycle check failed");
// Next-cycle implication.
`define TRFM_ASSERT_NEXT(label, clk, rst, pre, post) \
   label: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) \
      else $error("trfm: next-cycle check failed");
`else
`define TRFM_ASSERT_IMPL(label, clk, rst, pre, post)
`define TRFM_ASSERT_NEXT(label, clk, rst, pre, post)
`endif
`endif

>>> hdl/trfm_pkg.sv
// ============================================================================
// Two-range frequency meter package
// Shared widths, reset values, codes and control structs.
// ============================================================================
package trfm_pkg;

   localparam int CLOCK_HZ_W  = 26;
   localparam int THRESH_W    = 16;
   localparam int HOLDOFF_W   = 24;
   localparam int COARSE_W    = 16;
   localparam int FREQ_W      = 16;
   localparam int CSR_INDEX_W = 2;
   localparam int CSR_DATA_W  = 26;

   localparam int PRESCALE_BITS_DEF = 8;
   localparam int FINE_BITS_DEF     = 16;

   localparam logic [CLOCK_HZ_W-1:0] CLOCK_HZ_RST  = 26'd10000000;
   localparam logic [THRESH_W-1:0]   THRESH_RST    = 16'd170;
   localparam logic [HOLDOFF_W-1:0]  HOLDOFF_RST   = 24'd500000;

   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_CLOCK_HZ  = 2'd0,
      CSR_THRESHOLD = 2'd1,
      CSR_HOLDOFF   = 2'd2
   } csr_index_type;

   typedef enum logic [1:0] {
      PH_START = 2'd0,
      PH_END   = 2'd1,
      PH_HOLD  = 2'd2
   } phase_type;

   typedef enum logic [1:0] {
      DIV_IDLE   = 2'd0,
      DIV_RUN    = 2'd1,
      DIV_FINISH = 2'd2
   } div_state_type;

   typedef struct packed {
      logic start;
      logic fine;
   } div_cmd_type;

   typedef struct packed {
      logic busy;
      logic done;
   } div_status_type;

endpackage

>>> hdl/trfm_ifs.sv
// ============================================================================
// Two-range frequency meter channels
// Request channel carries one tick; response channel carries one result.
// ============================================================================
interface trfm_req_if;
   logic valid;
   logic ready;
   logic rising_edge;

   modport source (output valid, output rising_edge, input ready);
   modport sink (input valid, input rising_edge, output ready);
endinterface

interface trfm_rsp_if;
   logic        valid;
   logic        ready;
   logic [15:0] freq_hz;
   logic        saturated;
   logic        used_fine;

   modport source (output valid, output freq_hz, output saturated, output used_fine,
                   input ready);
   modport sink (input valid, input freq_hz, input saturated, input used_fine,
                 output ready);
endinterface

>>> hdl/trfm_ctrl.sv
// ============================================================================
// Two-range frequency meter tick control
// Fine, prescale and coarse counters plus the measurement phase machine.
// ============================================================================
module trfm_ctrl #(
   parameter int PRESCALE_BITS = trfm_pkg::PRESCALE_BITS_DEF,
   parameter int FINE_BITS     = trfm_pkg::FINE_BITS_DEF,
   parameter int DEN_W         = trfm_pkg::COARSE_W + trfm_pkg::PRESCALE_BITS_DEF
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             tick,
   input  logic                             rising_edge,
   input  logic [trfm_pkg::THRESH_W-1:0]    coarse_threshold,
   input  logic [trfm_pkg::HOLDOFF_W-1:0]   holdoff_ticks,
   output trfm_pkg::div_cmd_type            div_cmd,
   output logic [DEN_W-1:0]                 div_den
);

   logic [PRESCALE_BITS-1:0]          prescale_ff, prescale_in;
   logic [FINE_BITS-1:0]              fine_ff, fine_in;
   logic [FINE_BITS-1:0]              start_fine_ff, start_fine_in;
   logic [trfm_pkg::COARSE_W-1:0]     coarse_ff, coarse_in;
   logic [trfm_pkg::HOLDOFF_W-1:0]    holdoff_ff, holdoff_in;
   trfm_pkg::phase_type               phase_ff, phase_in;

   logic [trfm_pkg::HOLDOFF_W-1:0]    holdoff_dec;
   logic                              start_edge;
   logic                              end_edge;
   logic [FINE_BITS-1:0]              fine_diff;
   logic [DEN_W-1:0]                  coarse_ext;
   logic [DEN_W-1:0]                  coarse_scaled;
   logic                              use_fine;

   assign holdoff_dec = (holdoff_ff != '0) ? holdoff_ff - 1'b1 : '0;

   // Next phase.
   always_comb begin
      phase_in = phase_ff;
      case (phase_ff)
         trfm_pkg::PH_START: begin
            phase_in = rising_edge ? trfm_pkg::PH_END : trfm_pkg::PH_START;
         end
         trfm_pkg::PH_END: begin
            if (rising_edge) begin
               phase_in = (holdoff_ticks == '0) ? trfm_pkg::PH_START : trfm_pkg::PH_HOLD;
            end
         end
         trfm_pkg::PH_HOLD: begin
            if (holdoff_dec == '0) begin
               phase_in = trfm_pkg::PH_START;
            end
         end
         default: begin
            phase_in = rising_edge ? trfm_pkg::PH_END : trfm_pkg::PH_START;
         end
      endcase
   end

   // Phase outputs.
   always_comb begin
      start_edge = 1'b0;
      end_edge   = 1'b0;
      holdoff_in = holdoff_ff;
      case (phase_ff)
         trfm_pkg::PH_START: begin
            start_edge = rising_edge;
         end
         trfm_pkg::PH_END: begin
            end_edge = rising_edge;
            if (rising_edge) begin
               holdoff_in = holdoff_ticks;
            end
         end
         trfm_pkg::PH_HOLD: begin
            holdoff_in = holdoff_dec;
         end
         default: begin
            start_edge = rising_edge;
         end
      endcase
   end

   // Edges see the counters from before this tick's increment. A start edge
   // clears the coarse count and wins over a prescaler wrap.
   always_comb begin
      fine_in       = fine_ff + 1'b1;
      prescale_in   = prescale_ff + 1'b1;
      start_fine_in = start_edge ? fine_ff : start_fine_ff;
      coarse_in     = coarse_ff;
      if (start_edge) begin
         coarse_in = '0;
      end else if ((&prescale_ff) && (coarse_ff != '1)) begin
         coarse_in = coarse_ff + 1'b1;
      end
   end

   // The coarse divisor folds a divide by 2^P - 1 into the count:
   // clock_hz / (c * (2^P - 1)) gives the same floor as two divides.
   assign fine_diff     = fine_ff - start_fine_ff;
   assign coarse_ext    = DEN_W'(coarse_ff);
   assign coarse_scaled = (coarse_ext << PRESCALE_BITS) - coarse_ext;
   assign use_fine      = coarse_ff < coarse_threshold;

   assign div_cmd.start = tick && end_edge;
   assign div_cmd.fine  = use_fine;
   assign div_den       = use_fine ? DEN_W'(fine_diff) : coarse_scaled;

   always_ff @(posedge clock) begin
      if (reset) begin
         prescale_ff   <= '0;
         fine_ff       <= '0;
         start_fine_ff <= '0;
         coarse_ff     <= '0;
         holdoff_ff    <= '0;
         phase_ff      <= trfm_pkg::PH_START;
      end else if (tick) begin
         prescale_ff   <= prescale_in;
         fine_ff       <= fine_in;
         start_fine_ff <= start_fine_in;
         coarse_ff     <= coarse_in;
         holdoff_ff    <= holdoff_in;
         phase_ff      <= phase_in;
      end
   end

endmodule

>>> hdl/trfm_div.sv
// ============================================================================
// Two-range frequency meter divider
// Restoring divider, one quotient bit per cycle, with 16-bit saturation.
// ============================================================================
module trfm_div #(
   parameter int NUM_W = trfm_pkg::CLOCK_HZ_W,
   parameter int DEN_W = trfm_pkg::COARSE_W + trfm_pkg::PRESCALE_BITS_DEF
) (
   input  logic                             clock,
   input  logic                             reset,
   input  trfm_pkg::div_cmd_type            cmd,
   input  logic [NUM_W-1:0]                 num,
   input  logic [DEN_W-1:0]                 den,
   input  logic                             take,
   output trfm_pkg::div_status_type         status,
   output logic [trfm_pkg::FREQ_W-1:0]      quotient,
   output logic                             saturated,
   output logic                             used_fine
);

   localparam int CNT_W = $clog2(NUM_W);

   trfm_pkg::div_state_type state_ff, state_in;
   logic [CNT_W-1:0]        cnt_ff, cnt_in;
   logic [NUM_W-1:0]        quo_ff;
   logic [DEN_W-1:0]        rem_ff;
   logic [DEN_W-1:0]        den_ff;
   logic                    zero_ff;
   logic                    fine_ff;

   logic [DEN_W:0]          trial;
   logic [DEN_W:0]          trial_sub;
   logic                    fits;
   logic                    over;

   // Next state.
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         trfm_pkg::DIV_IDLE: begin
            if (cmd.start) begin
               state_in = trfm_pkg::DIV_RUN;
            end
         end
         trfm_pkg::DIV_RUN: begin
            if (cnt_ff == '0) begin
               state_in = trfm_pkg::DIV_FINISH;
            end
         end
         trfm_pkg::DIV_FINISH: begin
            if (take) begin
               state_in = trfm_pkg::DIV_IDLE;
            end
         end
         default: begin
            state_in = trfm_pkg::DIV_IDLE;
         end
      endcase
   end

   // State outputs.
   always_comb begin
      status.busy = 1'b1;
      status.done = 1'b0;
      case (state_ff)
         trfm_pkg::DIV_IDLE: begin
            status.busy = 1'b0;
         end
         trfm_pkg::DIV_FINISH: begin
            status.done = 1'b1;
         end
         default: begin
            status.busy = 1'b1;
         end
      endcase
   end

   // One restoring step: the numerator shifts out of the top of quo_ff while
   // quotient bits shift in at the bottom.
   assign trial     = {rem_ff, quo_ff[NUM_W-1]};
   assign trial_sub = trial - {1'b0, den_ff};
   assign fits      = trial >= {1'b0, den_ff};
   assign cnt_in    = cnt_ff - 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= trfm_pkg::DIV_IDLE;
         cnt_ff   <= '0;
      end else begin
         state_ff <= state_in;
         if (state_ff == trfm_pkg::DIV_IDLE) begin
            cnt_ff <= CNT_W'(NUM_W - 1);
         end else if (state_ff == trfm_pkg::DIV_RUN) begin
            cnt_ff <= cnt_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if ((state_ff == trfm_pkg::DIV_IDLE) && cmd.start) begin
         quo_ff  <= num;
         rem_ff  <= '0;
         den_ff  <= den;
         zero_ff <= (den == '0);
         fine_ff <= cmd.fine;
      end else if (state_ff == trfm_pkg::DIV_RUN) begin
         quo_ff <= {quo_ff[NUM_W-2:0], fits};
         rem_ff <= fits ? trial_sub[DEN_W-1:0] : trial[DEN_W-1:0];
      end
   end

   assign over      = zero_ff || (|quo_ff[NUM_W-1:trfm_pkg::FREQ_W]);
   assign quotient  = over ? '1 : quo_ff[trfm_pkg::FREQ_W-1:0];
   assign saturated = over;
   assign used_fine = fine_ff;

endmodule

>>> hdl/two_range_frequency_meter.sv
// ============================================================================
// Two-range frequency meter
// Reciprocal frequency meter with fine and coarse ranges and a holdoff.
// ============================================================================
// Each request is one tick of the reference clock with a flag for a rising
// edge of the measured signal. A tick without an ending edge leaves the
// meter ready for the next request. The tick that carries the ending edge
// is accepted and starts the shared restoring divider, which retires one
// quotient bit per cycle through its 26 divide steps and then hands the
// result to the output register; no request is taken until then. The
// hand-over waits while an earlier result still sits unread in the output
// register, so a stalled response side keeps the divider busy. The result
// then waits in the output register while new ticks are accepted.
`include "two_range_frequency_meter_assert.svh"

module two_range_frequency_meter #(
   parameter int PRESCALE_BITS = trfm_pkg::PRESCALE_BITS_DEF,
   parameter int FINE_BITS     = trfm_pkg::FINE_BITS_DEF
) (
   input  logic                               clock,
   input  logic                               reset,
   trfm_req_if.sink                           req_ch,
   trfm_rsp_if.source                         rsp_ch,
   input  logic                               csr_wr_en,
   input  logic [trfm_pkg::CSR_INDEX_W-1:0]   csr_index,
   input  logic [trfm_pkg::CSR_DATA_W-1:0]    csr_wdata
);

   localparam int COARSE_DEN_W = trfm_pkg::COARSE_W + PRESCALE_BITS;
   localparam int DEN_W = (FINE_BITS > COARSE_DEN_W) ? FINE_BITS : COARSE_DEN_W;

   logic [trfm_pkg::CLOCK_HZ_W-1:0] clock_hz_ff;
   logic [trfm_pkg::THRESH_W-1:0]   threshold_ff;
   logic [trfm_pkg::HOLDOFF_W-1:0]  holdoff_ff;

   logic                            rsp_valid_ff, rsp_valid_in;
   logic [trfm_pkg::FREQ_W-1:0]     freq_ff;
   logic                            sat_ff;
   logic                            fine_ff;

   trfm_pkg::div_cmd_type           div_cmd;
   trfm_pkg::div_status_type        div_status;
   logic [DEN_W-1:0]                div_den;
   logic [trfm_pkg::FREQ_W-1:0]     div_quotient;
   logic                            div_saturated;
   logic                            div_used_fine;
   logic                            tick;
   logic                            load;

   assign req_ch.ready = !div_status.busy;
   assign tick         = req_ch.valid && req_ch.ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         clock_hz_ff  <= trfm_pkg::CLOCK_HZ_RST;
         threshold_ff <= trfm_pkg::THRESH_RST;
         holdoff_ff   <= trfm_pkg::HOLDOFF_RST;
      end else if (csr_wr_en) begin
         case (csr_index)
            trfm_pkg::CSR_CLOCK_HZ: begin
               clock_hz_ff <= csr_wdata[trfm_pkg::CLOCK_HZ_W-1:0];
            end
            trfm_pkg::CSR_THRESHOLD: begin
               threshold_ff <= csr_wdata[trfm_pkg::THRESH_W-1:0];
            end
            trfm_pkg::CSR_HOLDOFF: begin
               holdoff_ff <= csr_wdata[trfm_pkg::HOLDOFF_W-1:0];
            end
            default: begin
               clock_hz_ff <= clock_hz_ff;
            end
         endcase
      end
   end

   trfm_ctrl #(
      .PRESCALE_BITS (PRESCALE_BITS),
      .FINE_BITS     (FINE_BITS),
      .DEN_W         (DEN_W)
   ) u_ctrl (
      .clock            (clock),
      .reset            (reset),
      .tick             (tick),
      .rising_edge      (req_ch.rising_edge),
      .coarse_threshold (threshold_ff),
      .holdoff_ticks    (holdoff_ff),
      .div_cmd          (div_cmd),
      .div_den          (div_den)
   );

   trfm_div #(
      .NUM_W (trfm_pkg::CLOCK_HZ_W),
      .DEN_W (DEN_W)
   ) u_div (
      .clock     (clock),
      .reset     (reset),
      .cmd       (div_cmd),
      .num       (clock_hz_ff),
      .den       (div_den),
      .take      (load),
      .status    (div_status),
      .quotient  (div_quotient),
      .saturated (div_saturated),
      .used_fine (div_used_fine)
   );

   // A finished quotient moves to the output register once it is free.
   assign load         = div_status.done && (!rsp_valid_ff || rsp_ch.ready);
   assign rsp_valid_in = load || (rsp_valid_ff && !rsp_ch.ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         freq_ff <= div_quotient;
         sat_ff  <= div_saturated;
         fine_ff <= div_used_fine;
      end
   end

   assign rsp_ch.valid     = rsp_valid_ff;
   assign rsp_ch.freq_hz   = freq_ff;
   assign rsp_ch.saturated = sat_ff;
   assign rsp_ch.used_fine = fine_ff;

   `TRFM_ASSERT_IMPL(a_start_only_idle, clock, reset, div_cmd.start, !div_status.busy)
   `TRFM_ASSERT_NEXT(a_stall_after_start, clock, reset, div_cmd.start, !req_ch.ready)
   `TRFM_ASSERT_NEXT(a_result_kept, clock, reset, div_status.done && !load, div_status.done)

endmodule
